// File: design/hsqrt_pkg.sv
// Shared types and constants for the Heron square root block.
// Depends on nothing; imported by heron_square_root.
package hsqrt_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned RootW   = 63;
  localparam int unsigned RoundsW = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ShiftW  = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned DivSteps = 64;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    STATUS_CONVERGED = 2'd0,
    STATUS_NEGATIVE  = 2'd1,
    STATUS_CAPPED    = 2'd2
  } status_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_TOL_SHIFT  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_ROUNDS = 2'd1;

  localparam logic [ShiftW-1:0]  TOL_SHIFT_RST  = 6'd33;
  localparam logic [RoundsW-1:0] MAX_ROUNDS_RST = 8'd64;

  localparam logic [RootW-1:0] ROOT_MAX = {RootW{1'b1}};

endpackage

// File: design/heron_square_root.sv
// Top level of the Heron square root block: sequencer, serial divider, output register.
// Depends on hsqrt_pkg.
//
// Each request carries one signed fixed-point value and yields one result: the square
// root (unsigned, same fraction width), the number of Heron rounds and a status. A
// negative value returns status "negative" with root 0 and no rounds; zero returns root 0
// after no rounds. Otherwise the guess starts at 2.0 and every round divides the value by
// the guess, averages quotient and guess into the new guess and stops once the distance
// between them is at most the quotient shifted right by tolerance_shift, or when
// max_rounds rounds have run (status "capped", max_rounds of 0 acts as 1). One round
// runs a setup step, the restoring divider (one quotient bit per cycle, a 64-bit
// subtract-compare being the limiting unit; skipped with a saturated quotient when the
// quotient cannot fit), and steps to average, form the difference and test it. The block
// takes one item at a time: s_axis_tready_o is high only while no item is in work. A
// finished result sits in the output register, so the next item can be accepted before
// the previous result is taken. Configuration writes are always accepted; write them
// only while the block is idle.
module heron_square_root
  import hsqrt_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // operand stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [63:0]         s_axis_tdata_i,   // [63:0] value
  // result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [79:0]         m_axis_tdata_o    // [62:0] root, [70:63] rounds,
                                                // [72:71] status, [79:73] zero
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_AVG   = 3'd3;
  localparam logic [2:0] S_DIFF  = 3'd4;
  localparam logic [2:0] S_TEST  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [RootW-1:0] GUESS_INIT = RootW'(2) << FRACTION_BITS;

  // configuration registers
  logic [ShiftW-1:0]  tol_shift_q;
  logic [RoundsW-1:0] max_rounds_q;
  logic [RoundsW-1:0] cap;

  // datapath registers
  logic [2:0]          state_q, state_d;
  logic [RootW-1:0]    val_q, val_d;
  logic [RootW-1:0]    guess_q, guess_d;
  logic [RootW-1:0]    approx_q, approx_d;
  logic [RootW-1:0]    diff_q, diff_d;
  logic [RootW-1:0]    tol_q, tol_d;
  logic [63:0]         rem_q, rem_d;
  logic [63:0]         dlo_q, dlo_d;
  logic [63:0]         quo_q, quo_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [RoundsW-1:0]  rounds_q, rounds_d;
  status_e             status_q, status_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [RootW-1:0]    out_root_q, out_root_d;
  logic [RoundsW-1:0]  out_rounds_q, out_rounds_d;
  status_e             out_status_q, out_status_d;

  // combinational helpers
  logic [63:0]      dividend;
  logic [63:0]      div_hi;
  logic [63:0]      div_lo;
  logic [RootW-1:0] guess_nz;
  logic [63:0]      rem_shift;
  logic             step_bit;
  logic [63:0]      quo_next;
  logic [63:0]      avg_sum;
  logic             in_take;
  logic             out_free;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign cap             = (max_rounds_q == '0) ? RoundsW'(1) : max_rounds_q;

  // split value << FRACTION_BITS into its upper and lower words
  assign dividend = {1'b0, val_q};
  assign div_hi   = dividend >> (64 - FRACTION_BITS);
  assign div_lo   = dividend << FRACTION_BITS;
  assign guess_nz = (guess_q == '0) ? RootW'(1) : guess_q;

  // one restoring division step; the remainder stays below the divisor, so no bit is lost
  assign rem_shift = {rem_q[62:0], dlo_q[63]};
  assign step_bit  = (rem_shift >= {1'b0, guess_q});
  assign quo_next  = {quo_q[62:0], step_bit};
  assign avg_sum   = {1'b0, approx_q} + {1'b0, guess_q};

  always_comb begin
    state_d      = state_q;
    val_d        = val_q;
    guess_d      = guess_q;
    approx_d     = approx_q;
    diff_d       = diff_q;
    tol_d        = tol_q;
    rem_d        = rem_q;
    dlo_d        = dlo_q;
    quo_d        = quo_q;
    cnt_d        = cnt_q;
    rounds_d     = rounds_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_root_d   = out_root_q;
    out_rounds_d = out_rounds_q;
    out_status_d = out_status_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          val_d    = s_axis_tdata_i[RootW-1:0];
          guess_d  = GUESS_INIT;
          approx_d = '0;
          rounds_d = '0;
          status_d = STATUS_CONVERGED;
          if (s_axis_tdata_i[63]) begin
            // negative operand: reject without iterating
            val_d    = '0;
            status_d = STATUS_NEGATIVE;
            state_d  = S_DONE;
          end else if (s_axis_tdata_i == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        guess_d = guess_nz;
        if (div_hi >= {1'b0, guess_nz}) begin
          // quotient cannot fit: saturate and skip the divider
          approx_d = ROOT_MAX;
          state_d  = S_AVG;
        end else begin
          rem_d   = div_hi;
          dlo_d   = div_lo;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = step_bit ? (rem_shift - {1'b0, guess_q}) : rem_shift;
        dlo_d = {dlo_q[62:0], 1'b0};
        quo_d = quo_next;
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          approx_d = quo_next[63] ? ROOT_MAX : quo_next[RootW-1:0];
          state_d  = S_AVG;
        end
      end
      S_AVG: begin
        guess_d  = avg_sum[63:1];
        rounds_d = rounds_q + RoundsW'(1);
        state_d  = S_DIFF;
      end
      S_DIFF: begin
        diff_d  = (approx_q >= guess_q) ? (approx_q - guess_q) : (guess_q - approx_q);
        tol_d   = approx_q >> tol_shift_q;
        state_d = S_TEST;
      end
      S_TEST: begin
        if (diff_q <= tol_q) begin
          status_d = STATUS_CONVERGED;
          state_d  = S_DONE;
        end else if (rounds_q >= cap) begin
          status_d = STATUS_CAPPED;
          state_d  = S_DONE;
        end else begin
          state_d = S_START;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_root_d   = approx_q;
          out_rounds_d = rounds_q;
          out_status_d = status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      tol_shift_q  <= TOL_SHIFT_RST;
      max_rounds_q <= MAX_ROUNDS_RST;
      cnt_q        <= '0;
      rounds_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      rounds_q    <= rounds_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_TOL_SHIFT:  tol_shift_q  <= cfg_data_i[ShiftW-1:0];
          REG_MAX_ROUNDS: max_rounds_q <= cfg_data_i[RoundsW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    val_q        <= val_d;
    guess_q      <= guess_d;
    approx_q     <= approx_d;
    diff_q       <= diff_d;
    tol_q        <= tol_d;
    rem_q        <= rem_d;
    dlo_q        <= dlo_d;
    quo_q        <= quo_d;
    status_q     <= status_d;
    out_root_q   <= out_root_d;
    out_rounds_q <= out_rounds_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_status_q, out_rounds_q, out_root_q};

  // the divider remainder stays below the divisor
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < {1'b0, guess_q}))
    else $error("divider remainder reached the divisor");

  // every test sees between one and cap rounds
  a_rounds_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TEST) |-> (rounds_q != '0 && rounds_q <= cap))
    else $error("round count out of range");

  // a rejected operand reports no root and no rounds
  a_negative_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q == STATUS_NEGATIVE) |-> (approx_q == '0 && rounds_q == '0))
    else $error("negative operand produced a root");

  // a capped result reports exactly the cap
  a_capped_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q == STATUS_CAPPED) |-> (rounds_q == cap))
    else $error("capped result with wrong round count");

  // a finished result moves into the output register and the block returns to idle
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not loaded");

endmodule

// File: tb/sv/tb_heron_square_root.sv
// Self-checking testbench for heron_square_root: directed table plus random phases,
// each result checked against a typed-in expectation or a fixed-point Heron predictor held in this file.
// Depends on hsqrt_pkg and heron_square_root.
module tb_heron_square_root;
  import hsqrt_pkg::*;

  localparam int unsigned FracBits      = 32;
  localparam int unsigned HoldAt        = 40;       // result index where the long stall starts
  localparam int unsigned HoldCycles    = 5000;
  localparam int unsigned WatchdogLimit = 100000;
  localparam int unsigned SettleCycles  = 150;
  localparam int          PhaseItems [6] = '{110, 70, 8, 40, 80, 70};

  typedef struct packed {
    logic [RootW-1:0]   root;
    logic [RoundsW-1:0] rounds;
    status_e            status;
  } root_result_t;

  typedef struct {
    logic [7:0]   tol_data;
    logic [7:0]   cap_data;
    logic [63:0]  operand;
    bit           given;      // expectation typed in below instead of predicted
    root_result_t want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                s_tvalid;
  logic                s_axis_tready_o;
  logic [63:0]         s_tdata;
  logic                m_axis_tvalid_o;
  logic                m_tready;
  logic [79:0]         m_axis_tdata_o;

  // Register copies used by the predictor
  logic [ShiftW-1:0]  tol_shift_q  = TOL_SHIFT_RST;
  logic [RoundsW-1:0] max_rounds_q = MAX_ROUNDS_RST;

  root_result_t pending_roots [$];
  int unsigned  operands_sent   = 0;
  int unsigned  negatives_sent  = 0;
  int unsigned  zeros_sent      = 0;
  int unsigned  capped_sent     = 0;
  int unsigned  settings_loaded = 0;
  int unsigned  roots_taken     = 0;
  int unsigned  mismatches      = 0;
  int unsigned  quiet_cycles    = 0;
  int           sender_quiet    = 0;
  int           receiver_quiet  = 0;

  always #5 clk = ~clk;

  heron_square_root #(
    .FRACTION_BITS(FracBits)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // (num << FracBits) / den, saturated to the 63-bit root range
  function automatic logic [RootW-1:0] fixed_divide(input logic [63:0] num,
                                                    input logic [63:0] den);
    logic [127:0] wide;
    logic [127:0] quot;
    if ((num >> (64 - FracBits)) >= den) return ROOT_MAX;
    wide = {64'd0, num} << FracBits;
    quot = wide / {64'd0, den};
    if (quot > {65'd0, ROOT_MAX}) return ROOT_MAX;
    return quot[RootW-1:0];
  endfunction

  // Run Heron rounds from a guess of 2.0 under the current register copies
  function automatic root_result_t heron_predict(input logic [63:0] operand);
    root_result_t res;
    logic [63:0]  guess;
    logic [63:0]  approx;
    logic [63:0]  diff;
    logic [RoundsW-1:0] cap;
    int unsigned  n;
    bit           done;
    res.root   = '0;
    res.rounds = '0;
    res.status = STATUS_CONVERGED;
    if (operand[63]) begin
      res.status = STATUS_NEGATIVE;
      return res;
    end
    if (operand == 64'd0) return res;
    guess  = 64'd2 << FracBits;
    approx = '0;
    cap    = (max_rounds_q == '0) ? RoundsW'(1) : max_rounds_q;
    n      = 0;
    done   = 1'b0;
    while (!done) begin
      if (guess == 64'd0) guess = 64'd1;
      approx = {1'b0, fixed_divide(operand, guess)};
      guess  = (approx + guess) >> 1;
      n++;
      diff = (approx >= guess) ? approx - guess : guess - approx;
      if (diff <= (approx >> tol_shift_q)) begin
        res.status = STATUS_CONVERGED;
        done = 1'b1;
      end else if (n >= cap) begin
        res.status = STATUS_CAPPED;
        done = 1'b1;
      end
    end
    res.root   = approx[RootW-1:0];
    res.rounds = n[RoundsW-1:0];
    return res;
  endfunction

  function automatic root_result_t outcome(input logic [RootW-1:0] root,
                                           input logic [RoundsW-1:0] rounds,
                                           input status_e status);
    outcome.root   = root;
    outcome.rounds = rounds;
    outcome.status = status;
  endfunction

  function automatic stim_row_t known(input logic [7:0] tol_data, input logic [7:0] cap_data,
                                      input logic [63:0] operand, input root_result_t want);
    known.tol_data = tol_data;
    known.cap_data = cap_data;
    known.operand  = operand;
    known.given    = 1'b1;
    known.want     = want;
  endfunction

  function automatic stim_row_t modeled(input logic [7:0] tol_data, input logic [7:0] cap_data,
                                        input logic [63:0] operand);
    modeled.tol_data = tol_data;
    modeled.cap_data = cap_data;
    modeled.operand  = operand;
    modeled.given    = 1'b0;
    modeled.want     = '0;
  endfunction

  // Mix of sign, magnitude and exact squares; full random words toggle every bit
  function automatic logic [63:0] pick_operand();
    logic [63:0] raw;
    logic [63:0] k;
    int unsigned pick;
    raw  = {$urandom(), $urandom()};
    pick = $urandom_range(0, 99);
    if (pick < 10) return raw | 64'h8000_0000_0000_0000;
    if (pick < 13) return 64'd0;
    if (pick < 45) return {1'b0, raw[62:0]};
    if (pick < 75) return {1'b0, raw[62:0]} >> $urandom_range(1, 62);
    if (pick < 92) begin
      k = 64'($urandom_range(1, 46340));
      return (k * k) << FracBits;
    end
    case ($urandom_range(0, 2))
      0:       return 64'd1;
      1:       return 64'h7FFF_FFFF_FFFF_FFFF;
      default: return 64'h0000_0001_0000_0000;
    endcase
  endfunction

  // Draw the idle gap before each request at random, with occasional runs of back-to-back requests
  task automatic draw_idle(inout int quiet, output int cycles);
    if (quiet > 0) begin
      quiet--;
      cycles = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      quiet  = $urandom_range(5, 30);
      cycles = 0;
    end else begin
      cycles = $urandom_range(0, 13);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance with valid held
  task automatic offer_operand(input logic [63:0] operand, input root_result_t want);
    int gap;
    draw_idle(sender_quiet, gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= operand;
    @(posedge clk);
    while (!s_axis_tready_o) @(posedge clk);
    pending_roots.push_back(want);
    operands_sent++;
    if (want.status == STATUS_NEGATIVE) negatives_sent++;
    if (operand == 64'd0) zeros_sent++;
    if (want.status == STATUS_CAPPED) capped_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every outstanding result has been taken
  task automatic finish_requests();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_roots.size() != 0);
  endtask

  // Write both registers back to back; only while the block is idle
  task automatic load_settings(input logic [7:0] tol_data, input logic [7:0] cap_data);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TOL_SHIFT;
    cfg_data  <= tol_data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    tol_shift_q = tol_data[ShiftW-1:0];
    @(negedge clk);
    cfg_index <= REG_MAX_ROUNDS;
    cfg_data  <= cap_data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    max_rounds_q = cap_data[RoundsW-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic check_result(input logic [79:0] word);
    root_result_t want;
    if (pending_roots.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h with nothing outstanding", word);
      return;
    end
    want = pending_roots.pop_front();
    if (word[62:0] !== want.root || word[70:63] !== want.rounds ||
        word[72:71] !== want.status || word[79:73] !== 7'd0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d root/rounds/status: want %h %0d %0d, got %h %0d %0d pad %h",
                 roots_taken, want.root, want.rounds, want.status,
                 word[62:0], word[70:63], word[72:71], word[79:73]);
    end
  endtask

  // Result side: stall per result, one long hold-off so the block backs up its input
  initial begin : result_sink
    int stall;
    m_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      draw_idle(receiver_quiet, stall);
      if (roots_taken == HoldAt) stall = HoldCycles;
      if (stall == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        @(posedge clk);
        while (!m_axis_tvalid_o) @(posedge clk);
        repeat (stall) @(negedge clk);
        m_tready <= 1'b1;
      end
      @(posedge clk);
      while (!m_axis_tvalid_o) @(posedge clk);
      check_result(m_axis_tdata_o);
      roots_taken++;
      @(negedge clk);
    end
  end

  // End the run if no request moves on any channel for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no request moved for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_roots.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t    plan [$];
    root_result_t want;
    logic [63:0]  operand;
    logic [7:0]   tol_data;
    logic [7:0]   cap_data;

    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TOL_SHIFT;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;

    // Reset settings: sign, zero, exact root of 4.0, extremes and alternating bits
    plan.push_back(known(8'd33, 8'd64, 64'h0000_0000_0000_0000,
                         outcome(63'd0, 8'd0, STATUS_CONVERGED)));
    plan.push_back(known(8'd33, 8'd64, 64'h8000_0000_0000_0000,
                         outcome(63'd0, 8'd0, STATUS_NEGATIVE)));
    plan.push_back(known(8'd33, 8'd64, 64'hFFFF_FFFF_FFFF_FFFF,
                         outcome(63'd0, 8'd0, STATUS_NEGATIVE)));
    plan.push_back(known(8'd33, 8'd64, 64'h0000_0004_0000_0000,
                         outcome(63'h2_0000_0000, 8'd1, STATUS_CONVERGED)));
    plan.push_back(modeled(8'd33, 8'd64, 64'h0000_0000_0000_0001));
    plan.push_back(modeled(8'd33, 8'd64, 64'h7FFF_FFFF_FFFF_FFFF));
    plan.push_back(modeled(8'd33, 8'd64, 64'h0000_0001_0000_0000));
    plan.push_back(known(8'd33, 8'd64, 64'hC000_0000_0000_0000,
                         outcome(63'd0, 8'd0, STATUS_NEGATIVE)));
    plan.push_back(modeled(8'd33, 8'd64, 64'h0000_0002_0000_0000));
    plan.push_back(known(8'd33, 8'd64, 64'hAAAA_AAAA_AAAA_AAAA,
                         outcome(63'd0, 8'd0, STATUS_NEGATIVE)));
    plan.push_back(modeled(8'd33, 8'd64, 64'h5555_5555_5555_5555));
    // Cap of one round: 1.0 stops capped at 0.5, 4.0 converges first
    plan.push_back(known(8'd33, 8'd1, 64'h0000_0001_0000_0000,
                         outcome(63'h8000_0000, 8'd1, STATUS_CAPPED)));
    plan.push_back(known(8'd33, 8'd1, 64'h0000_0004_0000_0000,
                         outcome(63'h2_0000_0000, 8'd1, STATUS_CONVERGED)));
    plan.push_back(modeled(8'd33, 8'd1, 64'h7FFF_FFFF_FFFF_FFFF));
    // A cap of zero behaves as one
    plan.push_back(known(8'd33, 8'd0, 64'h0000_0001_0000_0000,
                         outcome(63'h8000_0000, 8'd1, STATUS_CAPPED)));
    plan.push_back(modeled(8'd33, 8'd0, 64'h0000_0009_0000_0000));
    // Zero shift compares against the quotient itself
    plan.push_back(modeled(8'd0, 8'd64, 64'h0000_0001_0000_0000));
    plan.push_back(modeled(8'd0, 8'd64, 64'h7FFF_FFFF_FFFF_FFFF));
    plan.push_back(modeled(8'd0, 8'd64, 64'h0000_0000_0000_0001));
    // Tightest tolerance with the largest cap
    plan.push_back(modeled(8'd63, 8'd255, 64'h0000_0001_0000_0000));
    plan.push_back(modeled(8'd63, 8'd255, 64'h0000_0010_0000_0000));
    // Upper data bits of the shift write are dropped
    plan.push_back(modeled(8'hC5, 8'd10, 64'h1234_5678_9ABC_DEF0));
    plan.push_back(modeled(8'hC5, 8'd10, 64'h0000_0002_0000_0000));
    plan.push_back(modeled(8'd1, 8'd200, 64'h7FFF_FFFF_FFFF_FFFF));
    plan.push_back(modeled(8'd1, 8'd200, 64'h0000_0000_0000_0001));

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: reload registers whenever a row asks for other settings
    tol_data = 8'(TOL_SHIFT_RST);
    cap_data = MAX_ROUNDS_RST;
    foreach (plan[i]) begin
      if (plan[i].tol_data != tol_data || plan[i].cap_data != cap_data) begin
        tol_data = plan[i].tol_data;
        cap_data = plan[i].cap_data;
        finish_requests();
        load_settings(tol_data, cap_data);
      end
      want = plan[i].given ? plan[i].want : heron_predict(plan[i].operand);
      offer_operand(plan[i].operand, want);
    end

    // Random phases, each under its own register settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          tol_data = 8'(TOL_SHIFT_RST);
          cap_data = MAX_ROUNDS_RST;
        end
        1: begin
          tol_data = 8'($urandom_range(1, 40));
          cap_data = 8'($urandom_range(1, 80));
        end
        2: begin tol_data = 8'd63; cap_data = 8'd255; end
        3: begin tol_data = 8'd0; cap_data = 8'($urandom_range(1, 255)); end
        4: begin
          tol_data = 8'($urandom_range(10, 34));
          cap_data = 8'($urandom_range(100, 255));
        end
        default: begin
          tol_data = 8'($urandom_range(0, 255));
          cap_data = 8'($urandom_range(0, 255));
        end
      endcase
      finish_requests();
      load_settings(tol_data, cap_data);
      for (int i = 0; i < PhaseItems[p]; i++) begin
        // hold the sender once mid-phase until the block has fully drained
        if (p == 1 && i == 25) finish_requests();
        operand = pick_operand();
        want    = heron_predict(operand);
        offer_operand(operand, want);
      end
    end

    finish_requests();
    repeat (SettleCycles) @(negedge clk);

    $display("Covered %0d operands (%0d negative, %0d zero, %0d capped) under %0d settings;",
             operands_sent, negatives_sent, zeros_sent, capped_sent, settings_loaded + 1);
    $display("checked %0d results, %0d mismatched", roots_taken, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
design/hsqrt_pkg.sv
design/heron_square_root.sv
tb/sv/tb_heron_square_root.sv
